// File: src/touch_button_press_detector_defines.svh
// Assertion macros shared by the touch button press detector RTL.
`ifndef TOUCH_BUTTON_PRESS_DETECTOR_DEFINES_SVH
`define TOUCH_BUTTON_PRESS_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check, masked while reset is asserted
`define TBPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also runs during reset
`define TBPD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TBPD_ASSERT(label, prop, msg)
`define TBPD_ASSERT_RST(label, prop, msg)
`endif

`endif

// File: src/tbpd_pkg.sv
// Types, register indexes and reset values for the touch button press detector.
`default_nettype none

package tbpd_pkg;

  // Configuration register indexes
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_THR   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_RELEASE_THR = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LONG_MS     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE_MS = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SHIFT       = 3'd4;

  // Register reset values
  localparam logic [15:0] RST_PRESS_THR   = 16'd40;
  localparam logic [15:0] RST_RELEASE_THR = 16'd60;
  localparam logic [31:0] RST_LONG_MS     = 32'd1000;
  localparam logic [31:0] RST_DEBOUNCE_MS = 32'd50;
  localparam logic [3:0]  RST_SHIFT       = 4'd2;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_PRESSED  = 2'd1,
    ST_HELD     = 2'd2,
    ST_RELEASED = 2'd3
  } btn_state_t;

  typedef struct packed {
    logic [15:0] raw_sample;
    logic [31:0] time_ms;
    logic        ack_short;
    logic        ack_long;
  } tbpd_in_t;

  typedef struct packed {
    logic [15:0] smoothed_value;
    logic [1:0]  button_state;
    logic        short_pending;
    logic        long_pending;
  } tbpd_out_t;

  typedef struct packed {
    logic [15:0] press_threshold;
    logic [15:0] release_threshold;
    logic [31:0] long_press_ms;
    logic [31:0] debounce_ms;
    logic [3:0]  smooth_shift;
  } tbpd_cfg_t;

  typedef struct packed {
    logic [15:0] average;
    logic        seeded;
    btn_state_t  fsm;
    logic [31:0] last_time;
    logic [31:0] press_time;
    logic        short_flag;
    logic        long_flag;
  } tbpd_state_t;

endpackage

`default_nettype wire

// File: src/touch_button_press_detector.sv
// A request waits in the input register until the result slot frees up.
// Throughput: one request per cycle unless the result side stalls; the input
// register, the step logic and the result register form a two-stage pipe with
// the button state in between. Stalls back up through the input register.
// Reset (synchronous, rst_n low): registers to defaults, average unseeded,
// state idle, flags and timestamps zero, both pipe stages empty.
`default_nettype none
`include "touch_button_press_detector_defines.svh"

module touch_button_press_detector import tbpd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire tbpd_in_t           in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output tbpd_out_t               out_data,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [31:0]        cfg_wdata
);

  tbpd_cfg_t   cfg;
  tbpd_state_t st_r;
  tbpd_state_t st_nxt;
  tbpd_in_t    req_r;
  logic        req_valid_r;
  logic        req_valid_nxt;
  tbpd_out_t   res_r;
  tbpd_out_t   res_nxt;
  logic        res_valid_r;
  logic        res_valid_nxt;
  logic        in_take;
  logic        adv;

  tbpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tbpd_step u_step (
    .cfg (cfg),
    .cur (st_r),
    .req (req_r),
    .nxt (st_nxt),
    .res (res_nxt)
  );

  // Pipe control: the held request moves on when the result slot frees up
  assign adv      = req_valid_r & (~res_valid_r | ~out_stall);
  assign in_stall = req_valid_r & ~adv;
  assign in_take  = in_valid & ~in_stall;

  always_comb begin
    req_valid_nxt = req_valid_r;
    if (in_take) begin
      req_valid_nxt = 1'b1;
    end else if (adv) begin
      req_valid_nxt = 1'b0;
    end
    res_valid_nxt = res_valid_r;
    if (adv) begin
      res_valid_nxt = 1'b1;
    end else if (res_valid_r && !out_stall) begin
      res_valid_nxt = 1'b0;
    end
  end

  // Control and button state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
      st_r        <= '{average: 16'd0, seeded: 1'b0, fsm: ST_IDLE, last_time: 32'd0,
                       press_time: 32'd0, short_flag: 1'b0, long_flag: 1'b0};
    end else begin
      req_valid_r <= req_valid_nxt;
      res_valid_r <= res_valid_nxt;
      if (adv) begin
        st_r <= st_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r <= in_data;
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = res_valid_r;
  assign out_data  = res_r;

  // Checks
  `TBPD_ASSERT(a_req_kept, req_valid_r && !adv |=> req_valid_r, "held request lost")
  `TBPD_ASSERT(a_adv_result, adv |=> res_valid_r, "advanced request gave no result")
  `TBPD_ASSERT(a_seed_set, adv |=> st_r.seeded, "average not seeded after a step")
  `TBPD_ASSERT(a_rel_idle, adv && st_r.fsm == ST_RELEASED |=> st_r.fsm == ST_IDLE, "no idle")
  `TBPD_ASSERT_RST(a_rst_empty, !rst_n |=> !res_valid_r && !req_valid_r, "pipe not empty after reset")

endmodule

`default_nettype wire

// File: src/tbpd_cfg_regs.sv
// Configuration register file of the touch button press detector.
`default_nettype none

module tbpd_cfg_regs import tbpd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [31:0]        cfg_wdata,
  output tbpd_cfg_t               cfg
);

  tbpd_cfg_t cfg_r;
  tbpd_cfg_t cfg_nxt;

  // Decode the write; indexes past the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRESS_THR:   cfg_nxt.press_threshold   = cfg_wdata[15:0];
        CFG_RELEASE_THR: cfg_nxt.release_threshold = cfg_wdata[15:0];
        CFG_LONG_MS:     cfg_nxt.long_press_ms     = cfg_wdata;
        CFG_DEBOUNCE_MS: cfg_nxt.debounce_ms       = cfg_wdata;
        CFG_SHIFT:       cfg_nxt.smooth_shift      = cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_threshold   <= RST_PRESS_THR;
      cfg_r.release_threshold <= RST_RELEASE_THR;
      cfg_r.long_press_ms     <= RST_LONG_MS;
      cfg_r.debounce_ms       <= RST_DEBOUNCE_MS;
      cfg_r.smooth_shift      <= RST_SHIFT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: src/tbpd_step.sv
// One poll step: acknowledge, average update and button state machine.
`default_nettype none

module tbpd_step import tbpd_pkg::*; (
  input  wire tbpd_cfg_t   cfg,
  input  wire tbpd_state_t cur,
  input  wire tbpd_in_t    req,
  output tbpd_state_t      nxt,
  output tbpd_out_t        res
);

  logic [15:0] avg_base;
  logic [15:0] avg_new;
  logic [31:0] since_trans;
  logic [31:0] since_press;
  logic        debounced;
  logic        touched;
  logic        released;

  // Seeded exponential average; a - (a >> s) never underflows
  assign avg_base = cur.seeded ? cur.average : req.raw_sample;
  assign avg_new  = avg_base - (avg_base >> cfg.smooth_shift)
                  + (req.raw_sample >> cfg.smooth_shift);

  // Wrapping elapsed times
  assign since_trans = req.time_ms - cur.last_time;
  assign since_press = req.time_ms - cur.press_time;
  assign debounced   = since_trans > cfg.debounce_ms;
  assign touched     = avg_new < cfg.press_threshold;
  assign released    = avg_new > cfg.release_threshold;

  // Next state; acknowledges clear the flags before detection
  always_comb begin
    nxt            = cur;
    nxt.average    = avg_new;
    nxt.seeded     = 1'b1;
    nxt.short_flag = cur.short_flag & ~req.ack_short;
    nxt.long_flag  = cur.long_flag & ~req.ack_long;
    unique case (cur.fsm)
      ST_IDLE: begin
        if (touched && debounced) begin
          nxt.fsm        = ST_PRESSED;
          nxt.press_time = req.time_ms;
          nxt.last_time  = req.time_ms;
        end
      end
      ST_PRESSED: begin
        if (touched) begin
          if (since_press > cfg.long_press_ms) begin
            nxt.long_flag = 1'b1;
            nxt.fsm       = ST_HELD;
          end
        end else if (released && debounced) begin
          nxt.short_flag = 1'b1;
          nxt.fsm        = ST_RELEASED;
          nxt.last_time  = req.time_ms;
        end
      end
      ST_HELD: begin
        if (released && debounced) begin
          nxt.fsm       = ST_RELEASED;
          nxt.last_time = req.time_ms;
        end
      end
      ST_RELEASED: nxt.fsm = ST_IDLE;
      default:     nxt.fsm = ST_IDLE;
    endcase
  end

  // Result fields come from the updated state
  assign res.smoothed_value = nxt.average;
  assign res.button_state   = nxt.fsm;
  assign res.short_pending  = nxt.short_flag;
  assign res.long_pending   = nxt.long_flag;

endmodule

`default_nettype wire
